### rtl/lnv_pkg.sv
// shared types, constants and character-class functions of the login name validator
// used by lnv_name_tracker and login_name_validator_unit; depends on nothing else
`default_nettype none

package lnv_pkg;

   // length counter saturates here; one extra bit so the count can hold the limit itself
   localparam int COUNT_MAX = 4096;
   localparam int COUNT_W   = $clog2(COUNT_MAX + 1);
   localparam int LIMIT_W   = 12;
   localparam int CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_BAD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_CHECK = 2'd2;

   // character codes that the rules name
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // verdict codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_BAD_SEQ  = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   // configuration registers as seen by the tracker
   typedef struct packed {
      logic               allow_bad;
      logic [LIMIT_W-1:0] length_limit;
      logic               length_check;
   } cfg_type;

   // one item handed from the input register to the tracker
   typedef struct packed {
      logic       fire;
      logic [7:0] char_code;
      logic       present;
      logic       last;
   } step_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // c locale: bytes at 0x80 and above are not alphanumeric
   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   // space " # ' , / : ;
   function automatic logic is_forbidden(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h22) || (c == 8'h23) || (c == 8'h27) ||
             (c == 8'h2C) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3B);
   endfunction

   function automatic logic is_control(input logic [7:0] c);
      return (c < CH_SPACE) || (c == CH_DEL);
   endfunction

endpackage

`default_nettype wire

### rtl/lnv_name_tracker.sv
// per-name state (length count and flags) and the verdict for the name in progress
// depends on lnv_pkg
`default_nettype none

module lnv_name_tracker
   import lnv_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         step_type  step,
   input  wire         cfg_type   cfg,
   output status_type  status
);

   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   logic invalid_ff, invalid_in, invalid_upd;
   logic bad_ff, bad_in, bad_upd;
   logic digits_ff, digits_in, digits_upd;
   logic dots_ff, dots_in, dots_upd;
   logic dollar_ff, dollar_in, dollar_upd;
   logic take;
   logic first;
   logic [7:0] c;

   // flag update for one byte of the name
   always_comb begin
      take       = step.fire && step.present;
      c          = step.char_code;
      first      = (count_ff == '0);
      count_upd  = count_ff;
      invalid_upd = invalid_ff;
      bad_upd    = bad_ff;
      digits_upd = digits_ff;
      dots_upd   = dots_ff;
      dollar_upd = dollar_ff;
      if (take) begin
         if (count_ff < COUNT_W'(COUNT_MAX)) begin
            count_upd = count_ff + COUNT_W'(1);
         end
         invalid_upd = invalid_ff || (first && (c == CH_DASH)) || is_forbidden(c) ||
                       is_control(c);
         digits_upd  = digits_ff && is_digit(c);
         dots_upd    = dots_ff && (c == CH_DOT);
         // a dollar followed by anything was not the final byte
         dollar_upd  = !first && (c == CH_DOLLAR);
         if (first) begin
            bad_upd = bad_ff || dollar_ff ||
                      !(is_alnum(c) || (c == CH_UNDER) || (c == CH_DOT));
         end else begin
            bad_upd = bad_ff || dollar_ff ||
                      ((c != CH_DOLLAR) &&
                       !(is_alnum(c) || (c == CH_UNDER) || (c == CH_DOT) || (c == CH_DASH)));
         end
      end
   end

   // verdict from the state including this byte, in order of priority
   always_comb begin
      if (cfg.length_check && (count_upd > {1'b0, cfg.length_limit})) begin
         status = STATUS_TOO_LONG;
      end else if ((count_upd == '0) || invalid_upd || digits_upd ||
                   (dots_upd && (count_upd <= COUNT_W'(2)))) begin
         status = STATUS_INVALID;
      end else if (!cfg.allow_bad && bad_upd) begin
         status = STATUS_BAD_SEQ;
      end else begin
         status = STATUS_OK;
      end
   end

   // clear the name state after the final item
   always_comb begin
      if (step.fire && step.last) begin
         count_in   = '0;
         invalid_in = 1'b0;
         bad_in     = 1'b0;
         digits_in  = 1'b1;
         dots_in    = 1'b1;
         dollar_in  = 1'b0;
      end else begin
         count_in   = count_upd;
         invalid_in = invalid_upd;
         bad_in     = bad_upd;
         digits_in  = digits_upd;
         dots_in    = dots_upd;
         dollar_in  = dollar_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         invalid_ff <= 1'b0;
         bad_ff     <= 1'b0;
         digits_ff  <= 1'b1;
         dots_ff    <= 1'b1;
         dollar_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         invalid_ff <= invalid_in;
         bad_ff     <= bad_in;
         digits_ff  <= digits_in;
         dots_ff    <= dots_in;
         dollar_ff  <= dollar_in;
      end
   end

endmodule

`default_nettype wire

### rtl/login_name_validator_unit.sv
// top level of the login name validator: stream ports, input and result registers, csr
// depends on lnv_pkg and lnv_name_tracker
`default_nettype none

// Checks a user or group name that arrives at most one byte per transfer on the req channel;
// req_tlast marks the final item of a name and yields one verdict on the rsp channel.
// It takes one item every clock cycle unless a verdict waits with rsp_tready low, with
// any number of names back to back; each item is held in the input register, and as it
// moves on the verdict of a final item is loaded into the result register, which
// drives rsp_tvalid.
// The flag update for each byte is combinational logic between those registers.
// While a verdict waits with rsp_tready low, the input register holds and req_tready
// drops once it is full. Configuration is to be written through the csr port while no
// name is in flight; the block does not enforce this, and the csr port is always ready.

module login_name_validator_unit
   import lnv_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   // input channel
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [7:0]          req_tdata,   // [7:0] char_code
   input  wire                 req_tuser,   // [0] char_present
   input  wire                 req_tlast,   // last item of the name
   // result channel
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [7:0]          rsp_tdata,   // [0] name_ok, [2:1] status, [7:3] zero
   // configuration write channel
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [LIMIT_W-1:0]  csr_data
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_present_ff, in_last_ff;
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, status;
   cfg_type    cfg_ff, cfg_in;
   step_type   step;
   logic       advance;

   // the input register moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign step.fire      = advance;
   assign step.char_code = in_char_ff;
   assign step.present   = in_present_ff;
   assign step.last      = in_last_ff;

   lnv_name_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg_ff),
      .status (status)
   );

   // input register valid
   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // result register valid: loaded by the final item of a name
   always_comb begin
      if (advance) begin
         out_valid_in = in_last_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALLOW_BAD:    cfg_in.allow_bad    = csr_data[0];
            CSR_LENGTH_LIMIT: cfg_in.length_limit = csr_data;
            CSR_LENGTH_CHECK: cfg_in.length_check = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         cfg_ff.allow_bad    <= 1'b0;
         cfg_ff.length_limit <= LIMIT_W'(255);
         cfg_ff.length_check <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff    <= req_tdata;
         in_present_ff <= req_tuser;
         in_last_ff    <= req_tlast;
      end
      if (advance && in_last_ff) begin
         out_status_ff <= status;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_status_ff, (out_status_ff == STATUS_OK)};

endmodule

`default_nettype wire

### dv/name_verdict_checker.sv
// checker for the login name validator: watches the req, rsp and csr channels,
// predicts each name verdict and compares it with the rsp transfers
// depends on lnv_pkg for widths, register indexes, character codes and verdict codes

module name_verdict_checker
   import lnv_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   input  wire                 req_tready,
   input  wire  [7:0]          req_tdata,
   input  wire                 req_tuser,
   input  wire                 req_tlast,
   input  wire                 rsp_tvalid,
   input  wire                 rsp_tready,
   input  wire  [7:0]          rsp_tdata,
   input  wire                 csr_valid,
   input  wire                 csr_ready,
   input  wire  [CSR_IDX_W-1:0] csr_index,
   input  wire  [LIMIT_W-1:0]  csr_data,
   output int                  verdicts_waiting,
   output int                  mismatches
);

   // rsp_tdata layout, highest bit first
   typedef struct packed {
      logic [4:0] pad;
      status_type status;
      logic       name_ok;
   } verdict_type;

   // what has been gathered of the name so far
   typedef struct {
      logic [COUNT_W-1:0] count;
      logic               invalid;
      logic               bad_seq;
      logic               digits_only;
      logic               dots_only;
      logic               dollar_last;
   } name_state_type;

   logic               allow_bad;
   logic [LIMIT_W-1:0] length_limit;
   logic               length_check;
   name_state_type     cur_name;
   verdict_type        verdict_q[$];
   int                 failures = 0;

   function automatic name_state_type fresh_name();
      name_state_type s;
      s.count = '0;
      s.invalid = 1'b0;
      s.bad_seq = 1'b0;
      s.digits_only = 1'b1;
      s.dots_only = 1'b1;
      s.dollar_last = 1'b0;
      return s;
   endfunction

   // fold one byte of the name into the flags
   function automatic name_state_type absorb_char(name_state_type s, logic [7:0] c);
      logic first;
      logic digit;
      logic word;
      first = (s.count == 0);
      digit = c inside {[8'h30:8'h39]};
      word = digit || (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || c == CH_UNDER || c == CH_DOT;
      if (first && c == CH_DASH)
         s.invalid = 1'b1;
      // control bytes and space " # ' , / : ;
      if (c < CH_SPACE || c == CH_DEL ||
          c inside {8'h20, 8'h22, 8'h23, 8'h27, 8'h2C, 8'h2F, 8'h3A, 8'h3B})
         s.invalid = 1'b1;
      if (!digit)
         s.digits_only = 1'b0;
      if (c != CH_DOT)
         s.dots_only = 1'b0;
      // a dollar with anything after it was not the final byte
      if (s.dollar_last)
         s.bad_seq = 1'b1;
      s.dollar_last = 1'b0;
      if (first) begin
         if (!word)
            s.bad_seq = 1'b1;
      end else if (c == CH_DOLLAR) begin
         s.dollar_last = 1'b1;
      end else if (!(word || c == CH_DASH)) begin
         s.bad_seq = 1'b1;
      end
      if (s.count < COUNT_MAX)
         s.count = s.count + 1'b1;
      return s;
   endfunction

   // verdict priority: too long, invalid, bad sequence, ok
   function automatic verdict_type judge(name_state_type s);
      verdict_type v;
      v.pad = '0;
      if (length_check && s.count > length_limit)
         v.status = STATUS_TOO_LONG;
      else if (s.count == 0 || s.invalid || s.digits_only || (s.dots_only && s.count <= 2))
         v.status = STATUS_INVALID;
      else if (!allow_bad && s.bad_seq)
         v.status = STATUS_BAD_SEQ;
      else
         v.status = STATUS_OK;
      v.name_ok = (v.status == STATUS_OK);
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         allow_bad = 1'b0;
         length_limit = 12'd255;
         length_check = 1'b1;
         cur_name = fresh_name();
         verdict_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALLOW_BAD:    allow_bad = csr_data[0];
               CSR_LENGTH_LIMIT: length_limit = csr_data;
               CSR_LENGTH_CHECK: length_check = csr_data[0];
               default: ;
            endcase
         end
         // input transfer
         if (req_tvalid && req_tready) begin
            if (req_tuser)
               cur_name = absorb_char(cur_name, req_tdata);
            if (req_tlast) begin
               verdict_q.push_back(judge(cur_name));
               cur_name = fresh_name();
            end
         end
         // result transfer
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_type'(rsp_tdata);
            if (verdict_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected verdict: ok=%0b status=%0d pad=%h",
                           got.name_ok, got.status, got.pad);
            end else begin
               want = verdict_q.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10)
                     $display({"verdict mismatch: expected ok=%0b status=%0d pad=%h,",
                               " got ok=%0b status=%0d pad=%h"},
                              want.name_ok, want.status, want.pad,
                              got.name_ok, got.status, got.pad);
               end
            end
         end
      end
      verdicts_waiting <= verdict_q.size();
      mismatches <= failures;
   end

endmodule

### dv/tb.sv
// testbench top for login_name_validator_unit: clock, reset, name stimulus,
// register phases and the final verdict
// depends on lnv_pkg, the block itself and name_verdict_checker

module tb;
   import lnv_pkg::*;

   localparam int CYCLE_LIMIT  = 100_000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef logic [7:0] name_bytes_type[$];

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [7:0]           req_tdata = 8'h00;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   wire                  req_tready;
   wire                  rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   wire  [7:0]           rsp_tdata;
   logic                 csr_valid = 1'b0;
   wire                  csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0]   csr_data = '0;

   int verdicts_waiting;
   int mismatches;
   int items_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   login_name_validator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   name_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .verdicts_waiting (verdicts_waiting),
      .mismatches       (mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // rsp side stalls in bursts of random length
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // one req transfer, sometimes with a random idle burst ahead of it
   task automatic send_item(logic [7:0] code, logic present, logic last_flag);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tuser <= present;
      req_tlast <= last_flag;
      if (present || last_flag)
         items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // a whole name; empty_end closes it with an item that carries no byte
   task automatic send_name(name_bytes_type nm, bit empty_end);
      for (int i = 0; i < nm.size(); i++) begin
         if ($urandom_range(0, 19) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(nm[i], 1'b1, (i == nm.size() - 1) && !empty_end);
      end
      if (nm.size() == 0 || empty_end)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // stop sending until every verdict is back and the pipeline is empty
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [LIMIT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // one-bit registers get random upper bits, which the block must drop
   task automatic apply_settings(logic allow, logic [LIMIT_W-1:0] limit, logic check);
      write_reg(CSR_ALLOW_BAD, {11'($urandom_range(0, 2047)), allow});
      write_reg(CSR_LENGTH_LIMIT, limit);
      write_reg(CSR_LENGTH_CHECK, {11'($urandom_range(0, 2047)), check});
      write_reg(CSR_SPARE, 12'($urandom_range(0, 4095)));
      csr_valid <= 1'b0;
   endtask

   function automatic name_bytes_type text_bytes(string s);
      name_bytes_type nm;
      for (int i = 0; i < s.len(); i++)
         nm.push_back(s[i]);
      return nm;
   endfunction

   function automatic name_bytes_type letters(int n);
      name_bytes_type nm;
      repeat (n) nm.push_back(8'h61 + 8'($urandom_range(0, 25)));
      return nm;
   endfunction

   // characters of a well-formed name; lead excludes the dash
   function automatic logic [7:0] word_char(bit lead);
      case ($urandom_range(0, lead ? 6 : 7))
         0, 1: return 8'h61 + 8'($urandom_range(0, 25));
         2, 3: return 8'h41 + 8'($urandom_range(0, 25));
         4:    return 8'h30 + 8'($urandom_range(0, 9));
         5:    return CH_UNDER;
         6:    return CH_DOT;
         default: return CH_DASH;
      endcase
   endfunction

   // a byte that breaks one rule or another
   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 7))
         0: return CH_DOLLAR;
         1: return CH_DASH;
         2: return CH_DEL;
         3: return 8'($urandom_range(0, 31));
         4: return 8'($urandom_range(128, 255));
         5: begin
            case ($urandom_range(0, 7))
               0: return 8'h20;
               1: return 8'h22;
               2: return 8'h23;
               3: return 8'h27;
               4: return 8'h2C;
               5: return 8'h2F;
               6: return 8'h3A;
               default: return 8'h3B;
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed names, some with one broken byte, plus noise
   function automatic name_bytes_type random_name();
      name_bytes_type nm;
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      case ($urandom_range(0, 11))
         0: repeat (len) nm.push_back(8'h30 + 8'($urandom_range(0, 9)));
         1: repeat ($urandom_range(1, 3)) nm.push_back(CH_DOT);
         2: repeat (len) nm.push_back(8'($urandom_range(0, 255)));
         3: ;
         default: begin
            nm.push_back(word_char(1'b1));
            repeat (len - 1) nm.push_back(word_char(1'b0));
            if ($urandom_range(0, 3) == 0)
               nm[nm.size() - 1] = CH_DOLLAR;
            if ($urandom_range(0, 2) == 0)
               nm[$urandom_range(0, nm.size() - 1)] = odd_char();
         end
      endcase
      return nm;
   endfunction

   initial begin
      name_bytes_type nm;
      int goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed names under the reset settings
      send_name(text_bytes("a"), 1'b0);
      send_name(text_bytes(""), 1'b0);
      send_name(text_bytes("."), 1'b0);
      send_name(text_bytes(".."), 1'b0);
      send_name(text_bytes("..."), 1'b0);
      send_name(text_bytes("-a"), 1'b0);
      send_name(text_bytes("12"), 1'b0);
      send_name(text_bytes("a$"), 1'b0);
      send_name(text_bytes("a$b"), 1'b0);
      send_name(text_bytes("$"), 1'b0);
      send_name(text_bytes("a:"), 1'b0);
      nm = text_bytes("a");
      nm.push_back(8'h00);
      send_name(nm, 1'b0);
      nm = '{8'hFF};
      send_name(nm, 1'b0);
      nm = '{CH_DEL};
      send_name(nm, 1'b0);
      send_name(text_bytes("b_"), 1'b1);
      quiesce();

      // longer names: both sides of the limit edge, then the length check disabled
      apply_settings(1'b0, 12'd40, 1'b1);
      send_name(letters(40), 1'b0);
      send_name(letters(41), 1'b0);
      quiesce();
      apply_settings(1'b1, 12'd3, 1'b0);
      send_name(letters(60), 1'b0);
      send_name(text_bytes("$-"), 1'b0);
      quiesce();

      // random names over several register settings, the last phase without idling
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(1'b0, 12'd8, 1'b1);
            1: apply_settings(1'b1, 12'd0, 1'b1);
            2: apply_settings(1'b0, 12'd4095, 1'b0);
            3: apply_settings(1'b1, 12'($urandom_range(1, 12)), 1'b1);
            4: apply_settings(1'($urandom_range(0, 1)), 12'($urandom_range(0, 20)),
                              1'($urandom_range(0, 1)));
            default: apply_settings(1'b0, 12'd255, 1'b1);
         endcase
         calm = (phase == 5);
         goal = items_sent + 120;
         while (items_sent < goal)
            send_name(random_name(), $urandom_range(0, 4) == 0);
         quiesce();
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
